@@ hw/rtl/twi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_pkg
// types and fixed constants shared by the tf-idf weight table modules
// ----------------------------------------------------------------------------
package twi_pkg;

   // field widths fixed by the interface
   localparam int CMD_W     = 2;
   localparam int IMG_W     = 6;
   localparam int CL_W      = 8;
   localparam int VALUE_W   = 16;
   localparam int STATUS_W  = 2;
   localparam int CS_W      = 7;
   localparam int DF_W      = 7;

   // collection size after reset
   localparam logic [CS_W-1:0] CS_RESET = 7'd64;
   // document frequency saturates here
   localparam logic [DF_W-1:0] DF_MAX = 7'd127;

   // log2 result: 3 integer bits, 32 fraction bits
   localparam int LOG_FRAC_W = 32;
   localparam int LOG_W      = 35;
   localparam int LOG_LO_W   = 18;
   localparam int LOG_HI_W   = LOG_W - LOG_LO_W;

   // ln 2 in q28
   localparam int LN2_W = 28;
   localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065280;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_IDF    = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

   // operation kinds after classification
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_WEIGHT = 2'd1;
   localparam logic [1:0] KIND_IDF    = 2'd2;
   localparam logic [1:0] KIND_FIXED  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [IMG_W-1:0] image_index;
      logic [CL_W-1:0]  cluster_label;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // classified word passed from front to back
   typedef struct packed {
      logic [1:0]          kind;
      logic [STATUS_W-1:0] status;
      logic [IMG_W-1:0]    image;
      logic [CL_W-1:0]     cluster;
   } op_type;

endpackage
`default_nettype wire

@@ hw/rtl/twi_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module twi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/twi_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_front
// accepts request words, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module twi_front import twi_pkg::*; #(
   parameter int unsigned MAX_IMAGES   = 64,
   parameter int unsigned NUM_CLUSTERS = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clearing,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         op_valid,
   output op_type       op_head,
   input  wire logic    op_pop
);

   logic   img_ok;
   logic   cl_ok;
   op_type op_new;
   logic   push;

   op_type     q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // range checks and classification
   always_comb begin
      img_ok         = 32'(req_payload.image_index) < MAX_IMAGES;
      cl_ok          = 32'(req_payload.cluster_label) < NUM_CLUSTERS;
      op_new.image   = req_payload.image_index;
      op_new.cluster = req_payload.cluster_label;
      op_new.kind    = KIND_FIXED;
      op_new.status  = ST_OK;
      case (req_payload.cmd)
         CMD_ADD: begin
            if (img_ok && cl_ok) begin
               op_new.kind = KIND_ADD;
            end
         end
         CMD_WEIGHT: begin
            if (img_ok && cl_ok) begin
               op_new.kind = KIND_WEIGHT;
            end else begin
               op_new.status = ST_EMPTY;
            end
         end
         CMD_IDF: begin
            if (cl_ok) begin
               op_new.kind = KIND_IDF;
            end else begin
               op_new.status = ST_EMPTY;
            end
         end
         default: begin
            op_new.kind = KIND_FIXED;
         end
      endcase
   end

   assign req_ready = (count_ff != 2'd2) && !clearing;
   assign push      = req_valid && req_ready;
   assign op_valid  = count_ff != 2'd0;
   assign op_head   = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = op_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, op_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/twi_log2.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_log2
// log2 of a 7-bit integer with 32 fraction bits, one squaring per cycle
// ----------------------------------------------------------------------------
module twi_log2 import twi_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CS_W-1:0]  n,
   output logic                  done,
   output logic [LOG_W-1:0]      result
);

   logic [2:0]            msb;
   logic [30:0]           m_start;
   logic [61:0]           sq;
   logic [31:0]           sq_hi;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [30:0]           m_ff, m_in;
   logic [2:0]            int_ff, int_in;
   logic [LOG_FRAC_W-1:0] frac_ff, frac_in;

   // normalise the operand into [2^30, 2^31)
   always_comb begin
      msb = 3'd0;
      for (int i = 0; i < CS_W; i++) begin
         if (n[i]) begin
            msb = 3'(i);
         end
      end
      m_start = 31'(n) << (5'd30 - {2'b0, msb});
   end

   // one squaring step
   always_comb begin
      sq    = m_ff * m_ff;
      sq_hi = sq[61:30];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      int_in  = int_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd31;
         m_in    = m_start;
         int_in  = msb;
         frac_in = '0;
      end else if (busy_ff) begin
         frac_in = {frac_ff[LOG_FRAC_W-2:0], sq_hi[31]};
         m_in    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      int_ff  <= int_in;
      frac_ff <= frac_in;
   end

   assign done   = done_ff;
   assign result = {int_ff, frac_ff};

endmodule
`default_nettype wire

@@ hw/rtl/twi_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_back
// owns the count stores, carries out add and read words, holds the result
// ----------------------------------------------------------------------------
module twi_back import twi_pkg::*; #(
   parameter int unsigned MAX_IMAGES   = 64,
   parameter int unsigned NUM_CLUSTERS = 256,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [CS_W-1:0] collection_size,
   output logic                 clearing,
   input  wire logic            op_valid,
   input  wire op_type          op_head,
   output logic                 op_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_payload
);

   localparam int TERM_DEPTH = MAX_IMAGES * NUM_CLUSTERS;
   localparam int TERM_AW    = $clog2(TERM_DEPTH);
   localparam int IMG_AW     = $clog2(MAX_IMAGES);
   localparam int CL_AW      = $clog2(NUM_CLUSTERS);
   localparam int WP         = 32 + COUNT_BITS;
   localparam int DC_W       = $clog2(WP);

   localparam logic [TERM_AW-1:0]    CLR_LAST  = TERM_AW'(TERM_DEPTH - 1);
   localparam logic [TERM_AW:0]      IMG_LIM   = (TERM_AW + 1)'(MAX_IMAGES);
   localparam logic [TERM_AW:0]      CL_LIM    = (TERM_AW + 1)'(NUM_CLUSTERS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [DC_W-1:0]       DIV_LAST  = DC_W'(WP - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_LOGA  = 4'd4;
   localparam logic [3:0] S_LOGB  = 4'd5;
   localparam logic [3:0] S_MUL0  = 4'd6;
   localparam logic [3:0] S_MUL1  = 4'd7;
   localparam logic [3:0] S_ROUND = 4'd8;
   localparam logic [3:0] S_WMUL  = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_WRND  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0]            state_ff, state_in;
   logic [TERM_AW-1:0]    clr_ff, clr_in;
   op_type                op_ff, op_in;
   logic [TERM_AW-1:0]    taddr_ff, taddr_in;
   logic [LOG_W-1:0]      la_ff, la_in;
   logic [LOG_W-1:0]      diff_ff, diff_in;
   logic [63:0]           prod_ff, prod_in;
   logic [31:0]           l28_ff, l28_in;
   logic [WP-1:0]         dq_ff, dq_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [DC_W-1:0]       dcnt_ff, dcnt_in;
   logic [VALUE_W-1:0]    rval_ff, rval_in;
   logic [STATUS_W-1:0]   rst_ff, rst_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0] term_rd, tot_rd;
   logic [DF_W-1:0]       df_rd;
   logic                  term_we, tot_we, df_we;
   logic [TERM_AW-1:0]    term_wa;
   logic [IMG_AW-1:0]     tot_wa;
   logic [CL_AW-1:0]      df_wa;
   logic [COUNT_BITS-1:0] term_wd, tot_wd;
   logic [DF_W-1:0]       df_wd;

   logic                  log_start;
   logic [CS_W-1:0]       log_n;
   logic                  log_done;
   logic [LOG_W-1:0]      log_res;

   logic [64:0]           rnd_sum;
   logic [COUNT_BITS:0]   rem_sh;
   logic [WP:0]           wsum;

   // count stores
   twi_ram #(.WIDTH(COUNT_BITS), .DEPTH(TERM_DEPTH)) u_term (
      .clock   (clock),
      .wr_en   (term_we),
      .wr_addr (term_wa),
      .wr_data (term_wd),
      .rd_addr (taddr_ff),
      .rd_data (term_rd)
   );

   twi_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_IMAGES)) u_total (
      .clock   (clock),
      .wr_en   (tot_we),
      .wr_addr (tot_wa),
      .wr_data (tot_wd),
      .rd_addr (IMG_AW'(op_ff.image)),
      .rd_data (tot_rd)
   );

   twi_ram #(.WIDTH(DF_W), .DEPTH(NUM_CLUSTERS)) u_df (
      .clock   (clock),
      .wr_en   (df_we),
      .wr_addr (df_wa),
      .wr_data (df_wd),
      .rd_addr (CL_AW'(op_ff.cluster)),
      .rd_data (df_rd)
   );

   // shared log2 unit, used for both operands of the ratio
   twi_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .n      (log_n),
      .done   (log_done),
      .result (log_res)
   );

   assign clearing = state_ff == S_CLEAR;

   // store writes: clearing sweep or add update
   always_comb begin
      term_wa = taddr_ff;
      tot_wa  = IMG_AW'(op_ff.image);
      df_wa   = CL_AW'(op_ff.cluster);
      term_we = 1'b0;
      tot_we  = 1'b0;
      df_we   = 1'b0;
      term_wd = (term_rd == COUNT_MAX) ? term_rd : term_rd + 1'b1;
      tot_wd  = (tot_rd == COUNT_MAX) ? tot_rd : tot_rd + 1'b1;
      df_wd   = (term_rd == '0 && df_rd != DF_MAX) ? df_rd + 1'b1 : df_rd;
      if (state_ff == S_CLEAR) begin
         term_wa = clr_ff;
         tot_wa  = IMG_AW'(clr_ff);
         df_wa   = CL_AW'(clr_ff);
         term_we = 1'b1;
         tot_we  = {1'b0, clr_ff} < IMG_LIM;
         df_we   = {1'b0, clr_ff} < CL_LIM;
         term_wd = '0;
         tot_wd  = '0;
         df_wd   = '0;
      end else if (state_ff == S_EVAL && op_ff.kind == KIND_ADD) begin
         term_we = 1'b1;
         tot_we  = 1'b1;
         df_we   = 1'b1;
      end
   end

   // rounding helpers
   always_comb begin
      rnd_sum = {1'b0, prod_ff} +
                ((state_ff == S_ROUND && op_ff.kind == KIND_IDF) ?
                 (65'd1 << 47) : (65'd1 << 31));
      rem_sh  = {rem_ff, dq_ff[WP-1]};
      wsum    = {1'b0, dq_ff} + (WP + 1)'(17'h08000);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      taddr_in     = taddr_ff;
      la_in        = la_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      l28_in       = l28_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      rval_in      = rval_ff;
      rst_in       = rst_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      op_pop       = 1'b0;
      log_start    = 1'b0;
      log_n        = collection_size;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (op_valid) begin
               op_pop   = 1'b1;
               op_in    = op_head;
               taddr_in = TERM_AW'(op_head.image) * TERM_AW'(NUM_CLUSTERS) +
                          TERM_AW'(op_head.cluster);
               rval_in  = '0;
               rst_in   = op_head.status;
               state_in = (op_head.kind == KIND_FIXED) ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (op_ff.kind == KIND_ADD) begin
               if ((term_rd == '0 && df_rd == DF_MAX) || term_rd == COUNT_MAX ||
                   tot_rd == COUNT_MAX) begin
                  rst_in = ST_SAT;
               end
            end else if (df_rd == '0 || (op_ff.kind == KIND_WEIGHT && tot_rd == '0)) begin
               rst_in = ST_EMPTY;
            end else if (collection_size > df_rd) begin
               log_start = 1'b1;
               state_in  = S_LOGA;
            end
         end
         S_LOGA: begin
            if (log_done) begin
               la_in     = log_res;
               log_start = 1'b1;
               log_n     = df_rd;
               state_in  = S_LOGB;
            end
         end
         S_LOGB: begin
            if (log_done) begin
               diff_in  = la_ff - log_res;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            prod_in  = 64'(diff_ff[LOG_LO_W-1:0] * LN2_Q28);
            state_in = S_MUL1;
         end
         S_MUL1: begin
            prod_in  = prod_ff + (64'(diff_ff[LOG_W-1:LOG_LO_W] * LN2_Q28) << LOG_LO_W);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (op_ff.kind == KIND_IDF) begin
               rval_in  = (rnd_sum[64:48] > 17'h0FFFF) ? '1 : rnd_sum[63:48];
               state_in = S_DONE;
            end else begin
               l28_in   = rnd_sum[63:32];
               state_in = S_WMUL;
            end
         end
         S_WMUL: begin
            dq_in    = l28_ff * term_rd;
            rem_in   = '0;
            dcnt_in  = DIV_LAST;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_sh >= {1'b0, tot_rd}) begin
               rem_in = COUNT_BITS'(rem_sh - {1'b0, tot_rd});
               dq_in  = {dq_ff[WP-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[COUNT_BITS-1:0];
               dq_in  = {dq_ff[WP-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = S_WRND;
            end
         end
         S_WRND: begin
            rval_in  = (wsum[WP:16] > (WP - 15)'(16'hFFFF)) ? '1 : wsum[31:16];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_in.value  = rval_ff;
               rsp_in.status = rst_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      taddr_ff <= taddr_in;
      la_ff    <= la_in;
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      l28_ff   <= l28_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      rval_ff  <= rval_in;
      rst_ff   <= rst_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

@@ hw/rtl/tf_idf_weight_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tf_idf_weight_table
// bag-of-visual-words tf-idf table: keypoint counts, idf and weight reads
// ----------------------------------------------------------------------------
//  port group  dir  handshake          word
//  req_        in   req_valid/ready    req_type (cmd, image, cluster)
//  rsp_        out  rsp_valid/ready    rsp_type (value q4.12, status)
//  csr_        in   csr_wr_en          collection size, 7 bits
//
//  idf reads run two 32-step log2 passes when the collection size exceeds
//  the document frequency; weight reads add a 32+COUNT_BITS step divide
//  after reset a clearing sweep over all MAX_IMAGES*NUM_CLUSTERS cells runs
//  before req_ready rises; a two-word queue lets requests in while a
//  response is stalled
// ----------------------------------------------------------------------------
module tf_idf_weight_table import twi_pkg::*; #(
   parameter int unsigned MAX_IMAGES   = 64,
   parameter int unsigned NUM_CLUSTERS = 256,
   parameter int unsigned COUNT_BITS   = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_type         req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_type              rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [CS_W-1:0] csr_wr_data
);

   logic [CS_W-1:0] cs_ff, cs_in;
   logic            clearing;
   logic            op_valid;
   op_type          op_head;
   logic            op_pop;

   // collection size register
   assign cs_in = csr_wr_en ? csr_wr_data : cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= CS_RESET;
      end else begin
         cs_ff <= cs_in;
      end
   end

   twi_front #(
      .MAX_IMAGES   (MAX_IMAGES),
      .NUM_CLUSTERS (NUM_CLUSTERS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .op_valid    (op_valid),
      .op_head     (op_head),
      .op_pop      (op_pop)
   );

   twi_back #(
      .MAX_IMAGES   (MAX_IMAGES),
      .NUM_CLUSTERS (NUM_CLUSTERS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .collection_size (cs_ff),
      .clearing        (clearing),
      .op_valid        (op_valid),
      .op_head         (op_head),
      .op_pop          (op_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tf-idf weight table: keypoint adds, idf and
// weight reads checked against a bit-accurate fixed-point model of the table
// ----------------------------------------------------------------------------
module tb;
   import twi_pkg::*;

   localparam int N_IMG = 64;
   localparam int N_CL = 256;
   localparam longint unsigned CNT_MAX = 65535;
   localparam longint CYCLE_LIMIT = 2000000;
   // command code with no operation behind it
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CS_W-1:0] csr_wr_data = '0;

   // model state
   int unsigned counts[N_IMG*N_CL];
   int unsigned totals[N_IMG];
   int unsigned doc_freq[N_CL];
   int unsigned coll_size = 64;
   rsp_type pending_words[$];

   int errors = 0;
   longint cycles = 0;
   int hold_off = 0;
   bit drain_mode = 1'b1;

   tf_idf_weight_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tf_idf_weight_table regression: fail");
         $finish;
      end
   end

   // log2 with 32 fraction bits by repeated squaring
   function automatic longint unsigned log2_frac32(int unsigned n);
      int unsigned p;
      longint unsigned m, r;
      p = 0;
      while (p < 30 && (n >> (p + 1)) != 0) p++;
      m = longint'(n) << (30 - p);
      r = longint'(p) << 32;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            r = r | (64'd1 << i);
         end
      end
      return r;
   endfunction

   function automatic longint unsigned ln_q60(int unsigned a, int unsigned b);
      if (a <= b) return 0;
      return (log2_frac32(a) - log2_frac32(b)) * 64'd186065280;
   endfunction

   // predicted response for one request word, updating the table
   function automatic rsp_type table_response(req_type w);
      longint unsigned v, l, l28;
      logic [1:0] st;
      int unsigned ix;
      v = 0;
      st = ST_OK;
      ix = w.image_index * N_CL + w.cluster_label;
      if (w.cmd == CMD_ADD) begin
         if (counts[ix] == 0) begin
            if (doc_freq[w.cluster_label] < 127) doc_freq[w.cluster_label]++;
            else st = ST_SAT;
         end
         if (counts[ix] < CNT_MAX) counts[ix]++;
         else st = ST_SAT;
         if (totals[w.image_index] < CNT_MAX) totals[w.image_index]++;
         else st = ST_SAT;
      end else if (w.cmd == CMD_IDF) begin
         if (doc_freq[w.cluster_label] == 0) st = ST_EMPTY;
         else begin
            l = ln_q60(coll_size, doc_freq[w.cluster_label]);
            v = (l + (64'd1 << 47)) >> 48;
         end
      end else if (w.cmd == CMD_WEIGHT) begin
         if (doc_freq[w.cluster_label] == 0 || totals[w.image_index] == 0) st = ST_EMPTY;
         else begin
            l = ln_q60(coll_size, doc_freq[w.cluster_label]);
            l28 = (l + (64'd1 << 31)) >> 32;
            v = (l28 * counts[ix]) / totals[w.image_index];
            v = (v + (64'd1 << 15)) >> 16;
         end
      end
      if (v > 65535) v = 65535;
      table_response.value = v[15:0];
      table_response.status = st;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // send one word, predicting its response at acceptance
   // valid stays up after acceptance so words can follow back to back
   task automatic send_word(req_type w, bit idle_gaps = 1'b1);
      int g;
      g = idle_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(table_response(w));
   endtask

   task automatic word_of(logic [1:0] c, int unsigned im, int unsigned cl);
      req_type w;
      w.cmd = c;
      w.image_index = IMG_W'(im);
      w.cluster_label = CL_W'(cl);
      send_word(w);
   endtask

   // wait for all responses and the block to settle, then write the size
   task automatic set_collection(int unsigned cs);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= cs[CS_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      coll_size = cs & 7'h7f;
   endtask

   // response receiver with random stalls and a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= drain_mode ? 1'b1 : ($urandom_range(0, 99) < 70);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp_payload.value !== exp_w.value) begin
               $error("value expected %0d actual %0d", exp_w.value, rsp_payload.value);
               errors++;
            end
            if (rsp_payload.status !== exp_w.status) begin
               $error("status expected %0d actual %0d", exp_w.status, rsp_payload.status);
               errors++;
            end
         end
      end
   end

   // empty reads, extremes of fields, unused command
   task automatic test_directed();
      word_of(CMD_IDF, 0, 0);
      word_of(CMD_WEIGHT, 63, 255);
      word_of(CMD_SPARE, 63, 255);
      word_of(CMD_ADD, 0, 0);
      word_of(CMD_ADD, 63, 255);
      word_of(CMD_ADD, 63, 0);
      word_of(CMD_IDF, 0, 255);
      word_of(CMD_IDF, 0, 0);
      word_of(CMD_WEIGHT, 63, 255);
      word_of(CMD_WEIGHT, 0, 0);
      word_of(CMD_WEIGHT, 0, 255);
      word_of(CMD_WEIGHT, 5, 0);
      word_of(CMD_SPARE, 0, 0);
   endtask

   // doc frequency up to the image count on one cluster, ratio not above one
   task automatic test_df_saturation();
      for (int i = 0; i < N_IMG; i++) word_of(CMD_ADD, i, 200);
      word_of(CMD_IDF, 0, 200);
      word_of(CMD_WEIGHT, 3, 200);
   endtask

   // many back-to-back adds on one cell, then weight reads of that image
   task automatic test_heavy_count();
      req_type w;
      w.cmd = CMD_ADD;
      w.image_index = 6'd42;
      w.cluster_label = 8'd17;
      for (int i = 0; i < 100; i++) send_word(w, 1'b0);
      w.cluster_label = 8'd18;
      send_word(w, 1'b0);
      word_of(CMD_WEIGHT, 42, 17);
      word_of(CMD_WEIGHT, 42, 18);
   endtask

   // random mix, mostly adds to a small set of clusters, with reads in between
   task automatic test_random(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) word_of(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 15));
         else if (r < 70) word_of(CMD_WEIGHT, $urandom_range(0, 63), $urandom_range(0, 15));
         else if (r < 85) word_of(CMD_IDF, 0, $urandom_range(0, 15));
         else if (r < 95) word_of(2'($urandom_range(0, 2)), $urandom_range(0, 63),
                                  $urandom_range(0, 255));
         else word_of(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 255));
      end
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      hold_off = 400;
      for (int i = 0; i < 12; i++) word_of(CMD_ADD, i, 3);
      for (int i = 0; i < 6; i++) word_of(CMD_IDF, 0, i);
   endtask

   initial begin
      foreach (counts[i]) counts[i] = 0;
      foreach (totals[i]) totals[i] = 0;
      foreach (doc_freq[i]) doc_freq[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_mode = 1'b0;
      test_df_saturation();
      set_collection(1);
      word_of(CMD_IDF, 0, 0);
      test_random(300);
      set_collection(127);
      word_of(CMD_IDF, 0, 200);
      test_random(400);
      set_collection(0);
      word_of(CMD_IDF, 0, 0);
      word_of(CMD_WEIGHT, 0, 0);
      set_collection(64);
      test_backpressure();
      test_random(300);
      set_collection($urandom_range(2, 126));
      test_random(500);
      drain_mode = 1'b1;
      test_heavy_count();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("tf_idf_weight_table regression: pass");
      else $display("tf_idf_weight_table regression: fail");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/twi_pkg.sv
hw/rtl/twi_ram.sv
hw/rtl/twi_front.sv
hw/rtl/twi_log2.sv
hw/rtl/twi_back.sv
hw/rtl/tf_idf_weight_table.sv
tb/tb.sv
